FILE: rtl/bffa_pkg.sv
package bffa_pkg;

  // Internal address/size width, wide enough for the largest supported CAPACITY
  localparam int SZ_W  = 17;
  // Run length width, wide enough for the largest supported MAX_ALLOC
  localparam int CNT_W = 13;
  localparam int FIFO_DEPTH = 4;
  localparam int INIT_SIZE_RST = 256;

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_TOOLONG = 2'd2,
    ST_RANGE   = 2'd3
  } status_t;

  localparam logic RK_ALLOC = 1'b0;
  localparam logic RK_READ  = 1'b1;

  typedef enum logic [1:0] {
    CMD_BYTE = 2'd0,
    CMD_FREE = 2'd1,
    CMD_READ = 2'd2
  } cmd_kind_t;

  // One classified item on its way to the back end
  typedef struct packed {
    cmd_kind_t        kind;
    logic [7:0]       data;
    logic             last;
    logic             drop;      // byte beyond MAX_ALLOC, not staged
    logic             too_long;  // run overflowed somewhere
    logic [CNT_W-1:0] cnt;       // run length including this byte, capped at MAX_ALLOC
    logic [SZ_W-1:0]  lo;        // free start / read address
    logic [SZ_W-1:0]  hi;        // free end, clipped
  } cmd_t;

  typedef enum logic [2:0] {
    B_CLEAR  = 3'd0,
    B_IDLE   = 3'd1,
    B_FREE   = 3'd2,
    B_SRCH   = 3'd3,
    B_COPY   = 3'd4,
    B_RDWAIT = 3'd5,
    B_RESP   = 3'd6
  } bstate_t;

endpackage

FILE: rtl/bffa_front.sv
module bffa_front #(
  parameter int CAPACITY  = 4096,
  parameter int MAX_ALLOC = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_action,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_last_byte,
  input  logic [11:0]           in_address,
  input  logic [12:0]           in_free_length,
  input  logic                  clearing,
  input  logic                  fifo_full,
  output logic                  push,
  output bffa_pkg::cmd_t        cmd
);

  localparam int CNW = $clog2(MAX_ALLOC + 1);
  localparam int SW  = bffa_pkg::SZ_W;

  logic [CNW-1:0] count_r, count_nxt;
  logic           tl_r, tl_nxt;
  logic           accept;
  logic           dropped;
  logic [CNW-1:0] run_len;
  logic [SW-1:0]  sum;
  logic [SW-1:0]  hi;

  assign in_stall = fifo_full || clearing;
  assign accept   = in_valid && !in_stall;
  assign dropped  = (count_r == CNW'(MAX_ALLOC));
  assign run_len  = dropped ? count_r : count_r + 1'b1;
  assign sum      = SW'(in_address) + SW'(in_free_length);
  assign hi       = (sum > SW'(CAPACITY)) ? SW'(CAPACITY) : sum;

  always_comb begin
    count_nxt    = count_r;
    tl_nxt       = tl_r;
    push         = 1'b0;
    cmd          = '0;
    cmd.data     = in_data_byte;
    cmd.last     = in_last_byte;
    cmd.drop     = dropped;
    cmd.too_long = tl_r || dropped;
    cmd.cnt      = bffa_pkg::CNT_W'(run_len);
    cmd.lo       = SW'(in_address);
    cmd.hi       = hi;
    case (bffa_pkg::action_t'(in_action))
      bffa_pkg::ACT_ALLOC: begin
        cmd.kind = bffa_pkg::CMD_BYTE;
        if (accept) begin
          push = !(dropped && !in_last_byte);
          if (in_last_byte) begin
            count_nxt = '0;
            tl_nxt    = 1'b0;
          end else begin
            count_nxt = run_len;
            tl_nxt    = tl_r || dropped;
          end
        end
      end
      bffa_pkg::ACT_FREE: begin
        cmd.kind = bffa_pkg::CMD_FREE;
        // empty or fully clipped ranges do nothing
        push = accept && (SW'(in_address) < hi);
      end
      bffa_pkg::ACT_READ: begin
        cmd.kind = bffa_pkg::CMD_READ;
        push = accept;
      end
      default: begin
        cmd.kind = bffa_pkg::CMD_READ;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      tl_r    <= 1'b0;
    end else begin
      count_r <= count_nxt;
      tl_r    <= tl_nxt;
    end
  end

endmodule

FILE: rtl/bffa_fifo.sv
module bffa_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bffa_pkg::cmd_t wr_cmd,
  input  logic           pop,
  output bffa_pkg::cmd_t head,
  output logic           full,
  output logic           empty
);

  localparam int D  = bffa_pkg::FIFO_DEPTH;
  localparam int PW = $clog2(D);
  localparam int CW = $clog2(D + 1);

  bffa_pkg::cmd_t mem_r [D];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(D));
  assign empty   = (cnt_r == '0);
  assign head    = mem_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wp_nxt  = do_push ? ((wp_r == PW'(D - 1)) ? '0 : wp_r + 1'b1) : wp_r;
    rp_nxt  = do_pop  ? ((rp_r == PW'(D - 1)) ? '0 : rp_r + 1'b1) : rp_r;
    cnt_nxt = cnt_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: rtl/bffa_back.sv
module bffa_back #(
  parameter int CAPACITY  = 4096,
  parameter int MAX_ALLOC = 256
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_wr_en,
  input  logic [12:0]    cfg_initial_size,
  input  bffa_pkg::cmd_t head,
  input  logic           empty,
  output logic           pop,
  output logic           clearing,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           out_result_kind,
  output logic [11:0]    out_start_address,
  output logic [7:0]     out_read_byte,
  output logic [1:0]     out_status
);

  localparam int AW  = $clog2(CAPACITY);
  localparam int SW  = $clog2(CAPACITY + 1);
  localparam int CNW = $clog2(MAX_ALLOC + 1);
  localparam int STW = (MAX_ALLOC > 1) ? $clog2(MAX_ALLOC) : 1;
  localparam int XW  = bffa_pkg::SZ_W;
  localparam int RST_SIZE = (bffa_pkg::INIT_SIZE_RST > CAPACITY) ?
                            CAPACITY : bffa_pkg::INIT_SIZE_RST;

  bffa_pkg::bstate_t state_r, state_nxt;

  logic [SW-1:0]  ptr_r, ptr_nxt, end_r, end_nxt, active_r, active_nxt;
  logic [CNW-1:0] n_r, n_nxt, run_r, run_nxt, k_r, k_nxt, ck_r, ck_nxt;
  logic           sv_r, sv_nxt, cv_r, cv_nxt;
  logic [AW-1:0]  sidx_r, sidx_nxt, start_r, start_nxt;
  logic           res_kind_r, res_kind_nxt;
  logic [11:0]    res_start_r, res_start_nxt;
  logic [7:0]     res_byte_r, res_byte_nxt;
  logic [1:0]     res_status_r, res_status_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           out_kind_r, out_kind_nxt;
  logic [11:0]    out_start_r, out_start_nxt;
  logic [7:0]     out_byte_r, out_byte_nxt;
  logic [1:0]     out_status_r, out_status_nxt;

  // memories
  logic [7:0] stg_mem [MAX_ALLOC];
  logic [7:0] store_mem [CAPACITY];
  logic       mark_mem [CAPACITY];
  logic           stg_we;
  logic [STW-1:0] stg_wa, stg_ra;
  logic [7:0]     stg_q;
  logic           store_we;
  logic [AW-1:0]  store_wa, store_ra;
  logic [7:0]     store_wd, store_q;
  logic           mark_we, mark_wd, mark_q;
  logic [AW-1:0]  mark_wa, mark_ra;

  logic [CNW-1:0] run_inc;
  logic           hit, miss, copy_done, free_done, clear_done, out_free, rd_oor;
  logic           s_issue, c_issue;
  logic [XW-1:0]  start_calc, copy_addr, end_sum;

  assign pop        = (state_r == bffa_pkg::B_IDLE) && !empty;
  assign clearing   = (state_r == bffa_pkg::B_CLEAR);
  assign run_inc    = mark_q ? '0 : run_r + 1'b1;
  assign hit        = sv_r && (run_inc == n_r);
  assign miss       = sv_r && !hit && (sidx_r == AW'(CAPACITY - 1));
  assign copy_done  = cv_r && (ck_r == n_r - 1'b1);
  assign free_done  = (ptr_r + 1'b1 == end_r);
  assign clear_done = (ptr_r == SW'(CAPACITY - 1));
  assign out_free   = !out_valid_r || !out_stall;
  assign rd_oor     = (XW'(active_r) <= head.lo);
  assign start_calc = XW'(sidx_r) + XW'(1) - XW'(n_r);
  assign copy_addr  = XW'(start_r) + XW'(ck_r);
  assign end_sum    = XW'(start_r) + XW'(n_r);
  assign s_issue    = (ptr_r < SW'(CAPACITY)) && !hit && !miss;
  assign c_issue    = (k_r < n_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bffa_pkg::B_CLEAR: begin
        if (clear_done) state_nxt = bffa_pkg::B_IDLE;
      end
      bffa_pkg::B_IDLE: begin
        if (pop) begin
          case (head.kind)
            bffa_pkg::CMD_BYTE: begin
              if (head.last) begin
                state_nxt = head.too_long ? bffa_pkg::B_RESP : bffa_pkg::B_SRCH;
              end
            end
            bffa_pkg::CMD_FREE: state_nxt = bffa_pkg::B_FREE;
            bffa_pkg::CMD_READ: begin
              state_nxt = rd_oor ? bffa_pkg::B_RESP : bffa_pkg::B_RDWAIT;
            end
            default: state_nxt = bffa_pkg::B_IDLE;
          endcase
        end
      end
      bffa_pkg::B_FREE: begin
        if (free_done) state_nxt = bffa_pkg::B_IDLE;
      end
      bffa_pkg::B_SRCH: begin
        if (hit)       state_nxt = bffa_pkg::B_COPY;
        else if (miss) state_nxt = bffa_pkg::B_RESP;
      end
      bffa_pkg::B_COPY: begin
        if (copy_done) state_nxt = bffa_pkg::B_RESP;
      end
      bffa_pkg::B_RDWAIT: state_nxt = bffa_pkg::B_RESP;
      bffa_pkg::B_RESP: begin
        if (out_free) state_nxt = bffa_pkg::B_IDLE;
      end
      default: state_nxt = bffa_pkg::B_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    ptr_nxt        = ptr_r;
    end_nxt        = end_r;
    active_nxt     = active_r;
    n_nxt          = n_r;
    run_nxt        = run_r;
    k_nxt          = k_r;
    ck_nxt         = ck_r;
    sv_nxt         = 1'b0;
    cv_nxt         = 1'b0;
    sidx_nxt       = sidx_r;
    start_nxt      = start_r;
    res_kind_nxt   = res_kind_r;
    res_start_nxt  = res_start_r;
    res_byte_nxt   = res_byte_r;
    res_status_nxt = res_status_r;
    out_kind_nxt   = out_kind_r;
    out_start_nxt  = out_start_r;
    out_byte_nxt   = out_byte_r;
    out_status_nxt = out_status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    stg_we   = 1'b0;
    stg_wa   = STW'(head.cnt - 1'b1);
    stg_ra   = STW'(k_r);
    store_we = 1'b0;
    store_wa = AW'(copy_addr);
    store_wd = stg_q;
    store_ra = AW'(head.lo);
    mark_we  = 1'b0;
    mark_wa  = AW'(ptr_r);
    mark_wd  = 1'b0;
    mark_ra  = AW'(ptr_r);
    case (state_r)
      bffa_pkg::B_CLEAR: begin
        mark_we = 1'b1;
        ptr_nxt = clear_done ? '0 : ptr_r + 1'b1;
      end
      bffa_pkg::B_IDLE: begin
        if (pop) begin
          case (head.kind)
            bffa_pkg::CMD_BYTE: begin
              stg_we         = !head.drop;
              n_nxt          = CNW'(head.cnt);
              ptr_nxt        = '0;
              run_nxt        = '0;
              res_kind_nxt   = bffa_pkg::RK_ALLOC;
              res_start_nxt  = '0;
              res_byte_nxt   = '0;
              res_status_nxt = bffa_pkg::ST_TOOLONG;
            end
            bffa_pkg::CMD_FREE: begin
              ptr_nxt = SW'(head.lo);
              end_nxt = SW'(head.hi);
            end
            bffa_pkg::CMD_READ: begin
              res_kind_nxt   = bffa_pkg::RK_READ;
              res_start_nxt  = '0;
              res_byte_nxt   = '0;
              res_status_nxt = rd_oor ? bffa_pkg::ST_RANGE : bffa_pkg::ST_OK;
            end
            default: ;
          endcase
        end
      end
      bffa_pkg::B_FREE: begin
        mark_we = 1'b1;
        ptr_nxt = ptr_r + 1'b1;
      end
      bffa_pkg::B_SRCH: begin
        // read of mark i issued here, its bit evaluated in the next cycle
        if (s_issue) begin
          ptr_nxt  = ptr_r + 1'b1;
          sidx_nxt = AW'(ptr_r);
        end
        sv_nxt = s_issue;
        if (sv_r) run_nxt = run_inc;
        if (hit) begin
          start_nxt = AW'(start_calc);
          k_nxt     = '0;
        end
        if (miss) begin
          res_status_nxt = bffa_pkg::ST_NOSPACE;
          res_start_nxt  = '0;
        end
      end
      bffa_pkg::B_COPY: begin
        if (c_issue) k_nxt = k_r + 1'b1;
        cv_nxt = c_issue;
        ck_nxt = k_r;
        if (cv_r) begin
          store_we = 1'b1;
          mark_we  = 1'b1;
          mark_wd  = 1'b1;
          mark_wa  = AW'(copy_addr);
        end
        if (copy_done) begin
          if (end_sum > XW'(active_r)) active_nxt = SW'(end_sum);
          res_status_nxt = bffa_pkg::ST_OK;
          res_start_nxt  = 12'(start_r);
        end
      end
      bffa_pkg::B_RDWAIT: begin
        res_byte_nxt = store_q;
      end
      bffa_pkg::B_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = res_kind_r;
          out_start_nxt  = res_start_r;
          out_byte_nxt   = res_byte_r;
          out_status_nxt = res_status_r;
        end
      end
      default: ;
    endcase
    if (cfg_wr_en) begin
      active_nxt = (XW'(cfg_initial_size) > XW'(CAPACITY)) ?
                   SW'(CAPACITY) : SW'(cfg_initial_size);
    end
  end

  always_ff @(posedge clk) begin
    if (stg_we) stg_mem[stg_wa] <= head.data;
    stg_q <= stg_mem[stg_ra];
  end

  always_ff @(posedge clk) begin
    if (store_we) store_mem[store_wa] <= store_wd;
    store_q <= store_mem[store_ra];
  end

  always_ff @(posedge clk) begin
    if (mark_we) mark_mem[mark_wa] <= mark_wd;
    mark_q <= mark_mem[mark_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bffa_pkg::B_CLEAR;
      ptr_r       <= '0;
      active_r    <= SW'(RST_SIZE);
      sv_r        <= 1'b0;
      cv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      active_r    <= active_nxt;
      sv_r        <= sv_nxt;
      cv_r        <= cv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    end_r        <= end_nxt;
    n_r          <= n_nxt;
    run_r        <= run_nxt;
    k_r          <= k_nxt;
    ck_r         <= ck_nxt;
    sidx_r       <= sidx_nxt;
    start_r      <= start_nxt;
    res_kind_r   <= res_kind_nxt;
    res_start_r  <= res_start_nxt;
    res_byte_r   <= res_byte_nxt;
    res_status_r <= res_status_nxt;
    out_kind_r   <= out_kind_nxt;
    out_start_r  <= out_start_nxt;
    out_byte_r   <= out_byte_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_result_kind   = out_kind_r;
  assign out_start_address = out_start_r;
  assign out_read_byte     = out_byte_r;
  assign out_status        = out_status_r;

  // placed run never runs past the store
  a_copy_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bffa_pkg::B_COPY) |-> (XW'(start_r) + XW'(n_r) <= XW'(CAPACITY)))
    else $error("placed run exceeds capacity");

  // search stops as soon as the run is long enough
  a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bffa_pkg::B_SRCH) |-> (run_r < n_r))
    else $error("free run counter overshot");

  a_active_bound: assert property (@(posedge clk) disable iff (!rst_n)
    active_r <= SW'(CAPACITY))
    else $error("active size beyond capacity");

  a_copy_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bffa_pkg::B_COPY && cv_r) |-> (ck_r < n_r))
    else $error("copy index beyond run");

  // no command leaves the queue during the clearing pass
  a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bffa_pkg::B_CLEAR) |-> !pop)
    else $error("command popped while clearing");

endmodule

FILE: rtl/byte_first_fit_allocator.sv
// Byte-granular first-fit allocator. Allocation bytes (action 0) are staged
// one item per cycle while the back end is idle; the item flagged last
// triggers placement at the lowest run of free bytes (or a too-long status)
// and returns one result with the start address and status. Free (action 1)
// clears marks over a clipped range and returns nothing; read (action 2)
// returns one stored byte, or status 3 past the active size. A front end
// classifies items into a 4-entry command queue, so it keeps accepting
// while the back end works; results wait in an output register.
// The back end walks the mark memory one bit per cycle: a placement searches
// the marks and then copies the staged bytes in, a free walks its clipped
// range. After reset a clearing pass over all CAPACITY marks clears them;
// input stalls during it (config writes are taken).
module byte_first_fit_allocator #(
  parameter int CAPACITY  = 4096,
  parameter int MAX_ALLOC = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [12:0] cfg_initial_size,
  // input items
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic [11:0] in_address,
  input  logic [12:0] in_free_length,
  // result items
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_result_kind,
  output logic [11:0] out_start_address,
  output logic [7:0]  out_read_byte,
  output logic [1:0]  out_status
);

  bffa_pkg::cmd_t push_cmd, head;
  logic           push, pop, full, empty, clearing;

  // front: classify items, track run length and overflow
  bffa_front #(
    .CAPACITY  (CAPACITY),
    .MAX_ALLOC (MAX_ALLOC)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_data_byte   (in_data_byte),
    .in_last_byte   (in_last_byte),
    .in_address     (in_address),
    .in_free_length (in_free_length),
    .clearing       (clearing),
    .fifo_full      (full),
    .push           (push),
    .cmd            (push_cmd)
  );

  // command queue between front and back
  bffa_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_cmd (push_cmd),
    .pop    (pop),
    .head   (head),
    .full   (full),
    .empty  (empty)
  );

  // back: staging, search, copy, free walk, reads and result register
  bffa_back #(
    .CAPACITY  (CAPACITY),
    .MAX_ALLOC (MAX_ALLOC)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_initial_size  (cfg_initial_size),
    .head              (head),
    .empty             (empty),
    .pop               (pop),
    .clearing          (clearing),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_kind   (out_result_kind),
    .out_start_address (out_start_address),
    .out_read_byte     (out_read_byte),
    .out_status        (out_status)
  );

endmodule
